@@ sv/dgdt_pkg.sv @@
// dgdt_pkg: shared types, constants and helpers of the detection grid decoder
// used by every module of the block, depends on nothing

package dgdt_pkg;

   localparam int MAX_CLASSES = 256;
   localparam int MAX_GRID    = 64;

   localparam int CELL_W   = 6;
   localparam int GRID_W   = 7;
   localparam int Q16_W    = 16;
   localparam int CLASS_W  = 8;
   localparam int INDEX_W  = 12;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // dividend of the position divide: cell in the integer part, offset below
   localparam int DIVIDEND_W = CELL_W + Q16_W;
   localparam int DIV_STEP_W = $clog2(DIVIDEND_W);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [GRID_W-1:0] GRID_COLUMNS_RESET    = GRID_W'(7);
   localparam logic [GRID_W-1:0] GRID_ROWS_RESET       = GRID_W'(7);
   localparam logic [Q16_W-1:0]  SCORE_THRESHOLD_RESET = Q16_W'(13107);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_COLUMNS    = 2'd0,
      CSR_GRID_ROWS       = 2'd1,
      CSR_SCORE_THRESHOLD = 2'd2
   } csr_index_type;

   typedef enum logic {
      BACK_IDLE   = 1'b0,
      BACK_DIVIDE = 1'b1
   } back_state_type;

   typedef struct packed {
      logic [GRID_W-1:0] grid_columns;
      logic [GRID_W-1:0] grid_rows;
      logic [Q16_W-1:0]  score_threshold;
   } cfg_type;

   // one box waiting for its decode
   typedef struct packed {
      logic [CELL_W-1:0]  cell_column;
      logic [CELL_W-1:0]  cell_row;
      logic [Q16_W-1:0]   offset_x;
      logic [Q16_W-1:0]   offset_y;
      logic [Q16_W-1:0]   root_width;
      logic [Q16_W-1:0]   root_height;
      logic [Q16_W-1:0]   box_score;
      logic [CLASS_W-1:0] class_found;
      logic               no_class;
   } entry_type;

   // handshake between the queue and its two sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // zero counts as one, anything above the largest grid is clamped
   function automatic logic [GRID_W-1:0] eff_grid(input logic [GRID_W-1:0] v);
      logic [GRID_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = GRID_W'(1);
      end else if (v > GRID_W'(MAX_GRID)) begin
         r = GRID_W'(MAX_GRID);
      end
      return r;
   endfunction

endpackage

@@ sv/dgdt_front.sv @@
// dgdt_front: accepts class items, scores them against the threshold and
// queues every box that produces a result; depends on dgdt_pkg

module dgdt_front (
   input  logic                       clock,
   input  logic                       reset,
   input  dgdt_pkg::cfg_type          cfg,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [5:0]                 req_cell_column,
   input  logic [5:0]                 req_cell_row,
   input  logic [15:0]                req_offset_x,
   input  logic [15:0]                req_offset_y,
   input  logic [15:0]                req_root_width,
   input  logic [15:0]                req_root_height,
   input  logic [15:0]                req_box_confidence,
   input  logic [15:0]                req_class_probability,
   input  logic [7:0]                 req_class_number,
   input  logic                       req_last_class,
   input  dgdt_pkg::queue_status_type q_status,
   output logic                       q_push,
   output dgdt_pkg::entry_type        q_entry
);
   import dgdt_pkg::*;

   logic                   hit_seen_ff;
   logic                   hit_seen_in;
   logic [2*Q16_W-1:0]     product;
   logic [Q16_W-1:0]       score;
   logic                   kept;
   logic                   pass;
   logic                   unknown;
   logic                   accept;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   assign product = req_class_probability * req_box_confidence;
   assign score   = product[2*Q16_W-1:Q16_W];
   assign kept    = req_box_confidence > cfg.score_threshold;
   assign pass    = kept && (score >= cfg.score_threshold)
                    && ({1'b0, req_class_number} < (CLASS_W+1)'(MAX_CLASSES));
   assign unknown = kept && !pass && req_last_class && !hit_seen_ff;

   always_comb begin
      hit_seen_in = hit_seen_ff;
      if (accept) begin
         if (pass) begin
            hit_seen_in = 1'b1;
         end
         // end of box clears the flag, dropped boxes included
         if (req_last_class) begin
            hit_seen_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_seen_ff <= 1'b0;
      end else begin
         hit_seen_ff <= hit_seen_in;
      end
   end

   assign q_push = accept && (pass || unknown);

   always_comb begin
      q_entry.cell_column   = req_cell_column;
      q_entry.cell_row      = req_cell_row;
      q_entry.offset_x      = req_offset_x;
      q_entry.offset_y      = req_offset_y;
      q_entry.root_width    = req_root_width;
      q_entry.root_height   = req_root_height;
      q_entry.box_score     = pass ? score : req_box_confidence;
      q_entry.class_found   = pass ? req_class_number : '0;
      q_entry.no_class      = !pass;
   end

endmodule

@@ sv/dgdt_queue.sv @@
// dgdt_queue: short register queue of boxes between the front and the back
// depends on dgdt_pkg

module dgdt_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  dgdt_pkg::entry_type        push_entry,
   input  logic                       pop,
   output dgdt_pkg::entry_type        head,
   output dgdt_pkg::queue_status_type status
);
   import dgdt_pkg::*;

   entry_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic                   do_push;
   logic                   do_pop;

   assign status.full  = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ sv/dgdt_div.sv @@
// dgdt_div: restoring divider, one quotient bit per cycle, saturating at
// the Q0.16 maximum; depends on dgdt_pkg

module dgdt_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [dgdt_pkg::DIVIDEND_W-1:0]      dividend,
   input  logic [dgdt_pkg::GRID_W-1:0]          divisor,
   output logic                                 done,
   output logic [dgdt_pkg::Q16_W-1:0]           quotient
);
   import dgdt_pkg::*;

   logic                  busy_ff;
   logic                  busy_in;
   logic                  done_ff;
   logic                  done_in;
   logic [DIV_STEP_W-1:0] step_ff;
   logic [DIV_STEP_W-1:0] step_in;
   logic [GRID_W-1:0]     den_ff;
   logic [GRID_W-1:0]     den_in;
   logic [GRID_W-1:0]     rem_ff;
   logic [GRID_W-1:0]     rem_in;
   logic [DIVIDEND_W-1:0] num_ff;
   logic [DIVIDEND_W-1:0] num_in;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVIDEND_W-1:0] quo_in;
   logic [GRID_W:0]       rem_shift;
   logic [GRID_W:0]       rem_diff;
   logic                  fits;

   assign rem_shift = {rem_ff, num_ff[DIVIDEND_W-1]};
   assign rem_diff  = rem_shift - {1'b0, den_ff};
   assign fits      = rem_shift >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      step_in = step_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         step_in = '0;
         den_in  = divisor;
         rem_in  = '0;
         num_in  = dividend;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? rem_diff[GRID_W-1:0] : rem_shift[GRID_W-1:0];
         num_in = {num_ff[DIVIDEND_W-2:0], 1'b0};
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_STEP_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = (|quo_ff[DIVIDEND_W-1:Q16_W]) ? '1 : quo_ff[Q16_W-1:0];

endmodule

@@ sv/dgdt_back.sv @@
// dgdt_back: takes queued boxes, squares the size terms, forms the cell index
// and divides the position; holds the result register. depends on dgdt_pkg

module dgdt_back (
   input  logic                       clock,
   input  logic                       reset,
   input  dgdt_pkg::cfg_type          cfg,
   input  dgdt_pkg::entry_type        head,
   input  dgdt_pkg::queue_status_type q_status,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [15:0]                rsp_box_x,
   output logic [15:0]                rsp_box_y,
   output logic [15:0]                rsp_box_width,
   output logic [15:0]                rsp_box_height,
   output logic [15:0]                rsp_box_score,
   output logic [7:0]                 rsp_class_found,
   output logic                       rsp_no_class,
   output logic [11:0]                rsp_cell_index
);
   import dgdt_pkg::*;

   back_state_type      state_ff;
   back_state_type      state_in;
   logic                start;
   logic                finish;
   logic                x_done;
   logic                y_done;
   logic [Q16_W-1:0]    x_quo;
   logic [Q16_W-1:0]    y_quo;
   logic [GRID_W-1:0]   cols;
   logic [GRID_W-1:0]   rows;
   logic [2*Q16_W-1:0]  width_sq;
   logic [2*Q16_W-1:0]  height_sq;
   logic [CELL_W+GRID_W-1:0] row_base;

   logic [Q16_W-1:0]    width_ff;
   logic [Q16_W-1:0]    height_ff;
   logic [Q16_W-1:0]    score_ff;
   logic [CLASS_W-1:0]  class_ff;
   logic                unknown_ff;
   logic [INDEX_W-1:0]  index_ff;

   logic                out_valid_ff;
   logic                out_valid_in;
   logic [Q16_W-1:0]    out_x_ff;
   logic [Q16_W-1:0]    out_y_ff;
   logic [Q16_W-1:0]    out_width_ff;
   logic [Q16_W-1:0]    out_height_ff;
   logic [Q16_W-1:0]    out_score_ff;
   logic [CLASS_W-1:0]  out_class_ff;
   logic                out_unknown_ff;
   logic [INDEX_W-1:0]  out_index_ff;

   assign cols = eff_grid(cfg.grid_columns);
   assign rows = eff_grid(cfg.grid_rows);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!q_status.empty) begin
               state_in = BACK_DIVIDE;
            end
         end
         BACK_DIVIDE: begin
            if (finish) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      start  = 1'b0;
      finish = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            start = !q_status.empty;
         end
         BACK_DIVIDE: begin
            finish = x_done && y_done && (!out_valid_ff || rsp_ready);
         end
         default: begin
            start  = 1'b0;
            finish = 1'b0;
         end
      endcase
   end

   assign q_pop = start;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   dgdt_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .dividend ({head.cell_column, head.offset_x}),
      .divisor  (cols),
      .done     (x_done),
      .quotient (x_quo)
   );

   dgdt_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .dividend ({head.cell_row, head.offset_y}),
      .divisor  (rows),
      .done     (y_done),
      .quotient (y_quo)
   );

   assign width_sq  = head.root_width * head.root_width;
   assign height_sq = head.root_height * head.root_height;
   assign row_base  = head.cell_row * cols;

   always_ff @(posedge clock) begin
      if (start) begin
         width_ff   <= width_sq[2*Q16_W-1:Q16_W];
         height_ff  <= height_sq[2*Q16_W-1:Q16_W];
         score_ff   <= head.box_score;
         class_ff   <= head.class_found;
         unknown_ff <= head.no_class;
         // index wraps to its low bits
         index_ff   <= INDEX_W'(row_base) + INDEX_W'(head.cell_column);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (finish) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         out_x_ff       <= x_quo;
         out_y_ff       <= y_quo;
         out_width_ff   <= width_ff;
         out_height_ff  <= height_ff;
         out_score_ff   <= score_ff;
         out_class_ff   <= class_ff;
         out_unknown_ff <= unknown_ff;
         out_index_ff   <= index_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_box_x         = out_x_ff;
   assign rsp_box_y         = out_y_ff;
   assign rsp_box_width     = out_width_ff;
   assign rsp_box_height    = out_height_ff;
   assign rsp_box_score     = out_score_ff;
   assign rsp_class_found   = out_class_ff;
   assign rsp_no_class      = out_unknown_ff;
   assign rsp_cell_index    = out_index_ff;

endmodule

@@ sv/detection_grid_decode_threshold_top.sv @@
// detection_grid_decode_threshold_top: grid detection box decode with
// threshold; holds the csr bank, uses dgdt_pkg, dgdt_front, dgdt_queue, dgdt_back
//
//   channel  dir  handshake              beat
//   req_     in   req_valid/req_ready    one (box, class) item
//   rsp_     out  rsp_valid/rsp_ready    one decoded box
//   csr_     in   csr_valid/csr_ready    register index and write data
//
// an item that yields no box is taken while the two-entry queue has room
// a box passes through the back in order: the pop from the queue, the
// bit-serial position divide, then the output register
// reset clears the csr bank to its defaults, the queue and the class-hit flag
// a stalled rsp_ready holds the back; the front keeps taking items until the
// queue fills, and csr_ready is always high

module detection_grid_decode_threshold_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [5:0]  req_cell_column,
   input  logic [5:0]  req_cell_row,
   input  logic [15:0] req_offset_x,
   input  logic [15:0] req_offset_y,
   input  logic [15:0] req_root_width,
   input  logic [15:0] req_root_height,
   input  logic [15:0] req_box_confidence,
   input  logic [15:0] req_class_probability,
   input  logic [7:0]  req_class_number,
   input  logic        req_last_class,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_box_x,
   output logic [15:0] rsp_box_y,
   output logic [15:0] rsp_box_width,
   output logic [15:0] rsp_box_height,
   output logic [15:0] rsp_box_score,
   output logic [7:0]  rsp_class_found,
   output logic        rsp_no_class,
   output logic [11:0] rsp_cell_index,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [dgdt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dgdt_pkg::CSR_DATA_W-1:0] csr_data
);
   import dgdt_pkg::*;

   cfg_type          cfg_ff;
   cfg_type          cfg_in;
   logic             csr_write;
   logic             q_push;
   logic             q_pop;
   entry_type        q_entry;
   entry_type        q_head;
   queue_status_type q_status;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_GRID_COLUMNS:    cfg_in.grid_columns    = csr_data[GRID_W-1:0];
            CSR_GRID_ROWS:       cfg_in.grid_rows       = csr_data[GRID_W-1:0];
            CSR_SCORE_THRESHOLD: cfg_in.score_threshold = csr_data[Q16_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_columns    <= GRID_COLUMNS_RESET;
         cfg_ff.grid_rows       <= GRID_ROWS_RESET;
         cfg_ff.score_threshold <= SCORE_THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dgdt_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg_ff),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_cell_column       (req_cell_column),
      .req_cell_row          (req_cell_row),
      .req_offset_x          (req_offset_x),
      .req_offset_y          (req_offset_y),
      .req_root_width        (req_root_width),
      .req_root_height       (req_root_height),
      .req_box_confidence    (req_box_confidence),
      .req_class_probability (req_class_probability),
      .req_class_number      (req_class_number),
      .req_last_class        (req_last_class),
      .q_status              (q_status),
      .q_push                (q_push),
      .q_entry               (q_entry)
   );

   dgdt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   dgdt_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .head              (q_head),
      .q_status          (q_status),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_box_x         (rsp_box_x),
      .rsp_box_y         (rsp_box_y),
      .rsp_box_width     (rsp_box_width),
      .rsp_box_height    (rsp_box_height),
      .rsp_box_score     (rsp_box_score),
      .rsp_class_found   (rsp_class_found),
      .rsp_no_class      (rsp_no_class),
      .rsp_cell_index    (rsp_cell_index)
   );

endmodule
